FILE: design/pupk_pkg.sv
// shared types, constants and decode functions for the pixel unpack size block
package pupk_pkg;

	localparam int SIZE_BITS = 16;
	localparam int FIELD_W   = 16;
	localparam int SIZE_W    = (SIZE_BITS < FIELD_W) ? SIZE_BITS : FIELD_W;
	localparam logic [FIELD_W-1:0] SIZE_MASK = FIELD_W'((33'(1) << SIZE_W) - 33'(1));

	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int ALIGN_W  = 4;
	localparam int BPP_W    = 5;
	localparam int ROWS_W   = FIELD_W + 1;
	localparam int STRIDE_W = FIELD_W + BPP_W;
	localparam int PIXB_W   = ROWS_W + BPP_W;
	localparam int PROD_W   = ROWS_W + STRIDE_W;
	localparam int TOTAL_W  = PROD_W + 1;
	localparam int SPAN_W   = 32;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_BAD   = 2'd2;
	localparam status_t ST_OVF   = 2'd3;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_ALIGN    = 2'd0;
	localparam reg_idx_t REG_ROW_LEN  = 2'd1;
	localparam reg_idx_t REG_SKIP_ROW = 2'd2;
	localparam reg_idx_t REG_SKIP_PIX = 2'd3;

	localparam logic [ALIGN_W-1:0] ALIGN_1 = 4'd1;
	localparam logic [ALIGN_W-1:0] ALIGN_2 = 4'd2;
	localparam logic [ALIGN_W-1:0] ALIGN_4 = 4'd4;
	localparam logic [ALIGN_W-1:0] ALIGN_8 = 4'd8;

	localparam logic [15:0] FMT_RED       = 16'h1903;
	localparam logic [15:0] FMT_GREEN     = 16'h1904;
	localparam logic [15:0] FMT_BLUE      = 16'h1905;
	localparam logic [15:0] FMT_ALPHA     = 16'h1906;
	localparam logic [15:0] FMT_LUM       = 16'h1909;
	localparam logic [15:0] FMT_LUM_ALPHA = 16'h190A;
	localparam logic [15:0] FMT_RGB       = 16'h1907;
	localparam logic [15:0] FMT_BGR       = 16'h80E0;
	localparam logic [15:0] FMT_RGBA      = 16'h1908;
	localparam logic [15:0] FMT_BGRA      = 16'h80E1;

	localparam logic [15:0] TYP_BYTE        = 16'h1400;
	localparam logic [15:0] TYP_UBYTE       = 16'h1401;
	localparam logic [15:0] TYP_SHORT       = 16'h1402;
	localparam logic [15:0] TYP_USHORT      = 16'h1403;
	localparam logic [15:0] TYP_INT         = 16'h1404;
	localparam logic [15:0] TYP_UINT        = 16'h1405;
	localparam logic [15:0] TYP_FLOAT       = 16'h1406;
	localparam logic [15:0] TYP_US_4444     = 16'h8033;
	localparam logic [15:0] TYP_US_5551     = 16'h8034;
	localparam logic [15:0] TYP_US_565      = 16'h8363;
	localparam logic [15:0] TYP_UI_8888     = 16'h8035;
	localparam logic [15:0] TYP_UI_8888_REV = 16'h8367;

	typedef struct packed {
		logic [ALIGN_W-1:0] row_alignment;
		logic [FIELD_W-1:0] row_length;
		logic [FIELD_W-1:0] skip_rows;
		logic [FIELD_W-1:0] skip_pixels;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [BPP_W-1:0]  bpp;
		logic [FIELD_W-1:0] pixels;
		logic [ROWS_W-1:0] rows;
		logic [ROWS_W-1:0] pix;
		logic [2:0]        align_mask;
	} dec_t;

	function automatic logic [2:0] comp_count(input logic [15:0] fmt);
		logic [2:0] n;
		n = 3'd0;
		case (fmt) inside
			FMT_RED, FMT_GREEN, FMT_BLUE, FMT_ALPHA, FMT_LUM: n = 3'd1;
			FMT_LUM_ALPHA:                                    n = 3'd2;
			FMT_RGB, FMT_BGR:                                 n = 3'd3;
			FMT_RGBA, FMT_BGRA:                               n = 3'd4;
			default:                                          n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [BPP_W-1:0] bytes_per_pixel(input logic [15:0] fmt,
			input logic [15:0] typ);
		logic [2:0]       n;
		logic [BPP_W-1:0] b;
		n = comp_count(fmt);
		b = '0;
		case (typ) inside
			TYP_BYTE, TYP_UBYTE:               b = BPP_W'(n);
			TYP_SHORT, TYP_USHORT:             b = BPP_W'({n, 1'b0});
			TYP_INT, TYP_UINT, TYP_FLOAT:      b = BPP_W'({n, 2'b00});
			TYP_US_4444, TYP_US_5551, TYP_US_565: b = BPP_W'(2);
			TYP_UI_8888, TYP_UI_8888_REV:      b = BPP_W'(4);
			default:                           b = '0;
		endcase
		if (n == 3'd0) begin
			b = '0;
		end
		return b;
	endfunction

endpackage

FILE: design/pixel_unpack_image_size_core.sv
// top level of the texture upload byte span calculator
//
// channel   direction  handshake                     payload
// config    in/out     psel penable pwrite pready    paddr pwdata prdata
// item in   in         start high, busy low          width height pixel_format pixel_type
// result    out        done, one cycle               byte_span status
//
// one item per cycle; an item goes through the decode register, the s2 and s3 registers
// and the output register, where done rises with its result
// depth set by the decode, stride, row product and final sum stages
// busy stays low, the pipeline never holds an item
// asynchronous reset clears valid bits and loads the register reset values
module pixel_unpack_image_size_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pupk_pkg::ADDR_W-1:0]  paddr,
	input  logic [pupk_pkg::DATA_W-1:0]  pwdata,
	output logic [pupk_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [pupk_pkg::FIELD_W-1:0] width,
	input  logic [pupk_pkg::FIELD_W-1:0] height,
	input  logic [15:0]                  pixel_format,
	input  logic [15:0]                  pixel_type,
	output logic                         done,
	output logic [pupk_pkg::SPAN_W-1:0]  byte_span,
	output logic [1:0]                   status
);
	import pupk_pkg::*;

	cfg_t cfg;
	dec_t dec;

	assign busy = 1'b0;

	pupk_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pupk_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.width        (width),
		.height       (height),
		.pixel_format (pixel_format),
		.pixel_type   (pixel_type),
		.cfg          (cfg),
		.dec          (dec)
	);

	pupk_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (dec),
		.done      (done),
		.byte_span (byte_span),
		.status    (status)
	);

endmodule

FILE: design/pupk_cfg.sv
// apb register file holding the unpack state
module pupk_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pupk_pkg::ADDR_W-1:0] paddr,
	input  logic [pupk_pkg::DATA_W-1:0] pwdata,
	output logic [pupk_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output pupk_pkg::cfg_t              cfg
);
	import pupk_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;
	logic [ALIGN_W-1:0] wa;

	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite;
	assign wa     = pwdata[ALIGN_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_alignment <= ALIGN_4;
			cfg_q.row_length    <= '0;
			cfg_q.skip_rows     <= '0;
			cfg_q.skip_pixels   <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_ALIGN: begin
					if (wa == ALIGN_1 || wa == ALIGN_2 || wa == ALIGN_4 || wa == ALIGN_8) begin
						cfg_q.row_alignment <= wa;
					end
				end
				REG_ROW_LEN:  cfg_q.row_length  <= pwdata[FIELD_W-1:0];
				REG_SKIP_ROW: cfg_q.skip_rows   <= pwdata[FIELD_W-1:0];
				REG_SKIP_PIX: cfg_q.skip_pixels <= pwdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ALIGN:    prdata = DATA_W'(cfg_q.row_alignment);
			REG_ROW_LEN:  prdata = DATA_W'(cfg_q.row_length);
			REG_SKIP_ROW: prdata = DATA_W'(cfg_q.skip_rows);
			REG_SKIP_PIX: prdata = DATA_W'(cfg_q.skip_pixels);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: design/pupk_decode.sv
// first stage: format and type decode, size checks and row counts
module pupk_decode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [pupk_pkg::FIELD_W-1:0] width,
	input  logic [pupk_pkg::FIELD_W-1:0] height,
	input  logic [15:0]                  pixel_format,
	input  logic [15:0]                  pixel_type,
	input  pupk_pkg::cfg_t               cfg,
	output pupk_pkg::dec_t               dec
);
	import pupk_pkg::*;

	logic [FIELD_W-1:0] w;
	logic [FIELD_W-1:0] h;
	logic [FIELD_W-1:0] rl;
	logic [BPP_W-1:0]   bpp;
	status_t            st;
	dec_t               dec_s1;

	assign w   = width & SIZE_MASK;
	assign h   = height & SIZE_MASK;
	assign rl  = cfg.row_length & SIZE_MASK;
	assign bpp = bytes_per_pixel(pixel_format, pixel_type);

	always_comb begin
		if (w == '0 || h == '0) begin
			st = ST_EMPTY;
		end else if (bpp == '0) begin
			st = ST_BAD;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_s1 <= '0;
		end else begin
			dec_s1.valid      <= in_valid;
			dec_s1.status     <= st;
			dec_s1.bpp        <= bpp;
			dec_s1.pixels     <= (rl > w) ? rl : w;
			dec_s1.rows       <= ROWS_W'(cfg.skip_rows) + ROWS_W'(h) - ROWS_W'(1);
			dec_s1.pix        <= ROWS_W'(cfg.skip_pixels) + ROWS_W'(w);
			dec_s1.align_mask <= 3'(cfg.row_alignment - ALIGN_W'(1));
		end
	end

	assign dec = dec_s1;

endmodule

FILE: design/pupk_arith.sv
// stride, products, final sum and overflow check over three stages
module pupk_arith (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pupk_pkg::dec_t              dec,
	output logic                        done,
	output logic [pupk_pkg::SPAN_W-1:0] byte_span,
	output pupk_pkg::status_t           status
);
	import pupk_pkg::*;

	logic [STRIDE_W-1:0] raw;
	logic [STRIDE_W-1:0] msk;

	logic                valid_s2, valid_s3;
	status_t             status_s2, status_s3;
	logic [STRIDE_W-1:0] stride_s2;
	logic [ROWS_W-1:0]   rows_s2;
	logic [PIXB_W-1:0]   pixb_s2, pixb_s3;
	logic [PROD_W-1:0]   prod_s3;

	logic [TOTAL_W-1:0]  total;

	logic                done_q;
	logic [SPAN_W-1:0]   span_q;
	status_t             status_q;

	assign raw   = STRIDE_W'(dec.pixels) * STRIDE_W'(dec.bpp);
	assign msk   = STRIDE_W'(dec.align_mask);
	assign total = TOTAL_W'(prod_s3) + TOTAL_W'(pixb_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s2 <= dec.valid;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		status_s2 <= dec.status;
		stride_s2 <= (raw + msk) & ~msk;
		rows_s2   <= dec.rows;
		pixb_s2   <= PIXB_W'(dec.pix) * PIXB_W'(dec.bpp);

		status_s3 <= status_s2;
		prod_s3   <= PROD_W'(rows_s2) * PROD_W'(stride_s2);
		pixb_s3   <= pixb_s2;

		if (status_s3 != ST_OK) begin
			status_q <= status_s3;
			span_q   <= '0;
		end else if (total[TOTAL_W-1:SPAN_W] != '0) begin
			status_q <= ST_OVF;
			span_q   <= '0;
		end else begin
			status_q <= ST_OK;
			span_q   <= total[SPAN_W-1:0];
		end
	end

	assign done      = done_q;
	assign byte_span = span_q;
	assign status    = status_q;

endmodule
